// ----- rtl/pfs_pkg.sv -----
package pfs_pkg;

    // Message position counter width and derived widths.
    localparam int POS_BITS         = 16;
    localparam int MAX_VARINT_BYTES = 5;
    localparam int FIELD_W          = 29;
    localparam int VALUE_W          = 32;
    localparam int OFFSET_W         = 16;
    localparam int LENGTH_W         = 16;
    localparam int STATUS_W         = 3;
    localparam int CFG_INDEX_W      = 1;
    localparam int CFG_DATA_W       = 29;

    // Fixed skip lengths of the fixed-size wire types.
    localparam logic [VALUE_W-1:0] FIXED32_BYTES = 32'd4;
    localparam logic [VALUE_W-1:0] FIXED64_BYTES = 32'd8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_FIELD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_MODE  = 1'b1;

    // Wire types.
    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_LENGTH  = 3'd2;
    localparam logic [2:0] WIRE_FIXED32 = 3'd5;

    // Search modes.
    localparam logic MODE_VARINT = 1'b0;
    localparam logic MODE_BYTES  = 1'b1;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_VAL,
        PH_LEN,
        PH_SKIP,
        PH_MSKIP,
        PH_DONE
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_ABSENT    = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_PAST_END  = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    // A classified message byte as it travels from the front to the scanner.
    typedef struct packed {
        logic       last;
        logic       cont;
        logic [6:0] low7;
    } t_item;

    // Places seven payload bits of a varint byte at their position in the value.
    function automatic logic [VALUE_W-1:0] varint_part(input logic [6:0] low7,
                                                       input logic [2:0] shift);
        logic [38:0] wide;
        logic [4:0]  amount;
        amount = 5'({2'b00, shift} * 5'd7);
        wide   = 39'(low7) << amount;
        return wide[VALUE_W-1:0];
    endfunction

endpackage

// ----- rtl/pfs_if.sv -----
// Byte channel into the scanner.
interface pfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel out of the scanner.
interface pfs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  scan_status;
    logic [31:0] field_value;
    logic [15:0] field_offset;
    logic [15:0] field_length;

    modport source (output valid, output scan_status, output field_value,
                    output field_offset, output field_length, input ready);
    modport sink   (input valid, input scan_status, input field_value,
                    input field_offset, input field_length, output ready);
endinterface

// ----- rtl/pfs_front.sv -----
module pfs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pfs_in_if.sink         i_byte,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output pfs_pkg::t_item o_push_item
);
    import pfs_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Split each byte into its continuation flag and seven payload bits.
    always_comb begin
        n_item.last = i_byte.last_byte;
        n_item.cont = i_byte.data_byte[7];
        n_item.low7 = i_byte.data_byte[6:0];
    end

    // The input register refills whenever it is empty or drains this cycle.
    assign i_byte.ready = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/pfs_queue.sv -----
module pfs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  pfs_pkg::t_item i_push_item,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output pfs_pkg::t_item o_pop_item
);
    import pfs_pkg::*;

    t_item      r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_item   = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count of the two-entry queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ----- rtl/pfs_scan.sv -----
module pfs_scan (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pfs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_item_valid,
    output logic                                o_item_ready,
    input  pfs_pkg::t_item                      i_item,
    pfs_out_if.source                           o_result
);
    import pfs_pkg::*;

    // Configuration registers.
    logic [FIELD_W-1:0]  r_target;
    logic                r_mode;

    // Message scan state.
    t_phase              r_phase;
    t_phase              n_phase;
    logic [VALUE_W-1:0]  r_acc;
    logic [VALUE_W-1:0]  n_acc;
    logic [2:0]          r_shift;
    logic [2:0]          n_shift;
    logic [FIELD_W-1:0]  r_field;
    logic [FIELD_W-1:0]  n_field;
    logic [VALUE_W-1:0]  r_skip;
    logic [VALUE_W-1:0]  n_skip;
    logic [POS_BITS:0]   r_pos;
    logic [POS_BITS:0]   n_pos;
    t_status             r_status;
    t_status             n_status;
    logic [VALUE_W-1:0]  r_value;
    logic [VALUE_W-1:0]  n_value;
    logic [OFFSET_W-1:0] r_offset;
    logic [OFFSET_W-1:0] n_offset;
    logic [LENGTH_W-1:0] r_length;
    logic [LENGTH_W-1:0] n_length;

    // Result register.
    logic                r_out_valid;
    t_status             r_res_status;
    logic [VALUE_W-1:0]  r_res_value;
    logic [OFFSET_W-1:0] r_res_offset;
    logic [LENGTH_W-1:0] r_res_length;
    t_status             res_status;
    logic [VALUE_W-1:0]  res_value;
    logic [OFFSET_W-1:0] res_offset;
    logic [LENGTH_W-1:0] res_length;

    // Shared decode of the current byte.
    logic                pop;
    logic                over;
    logic [VALUE_W-1:0]  v_acc;
    logic                v_done;
    logic                v_bad;
    logic                match;
    logic [2:0]          tag_wire;
    logic [POS_BITS:0]   pos_inc;
    logic                skip_last;

    // Only a closing byte needs room in the result register.
    assign o_item_ready = !i_item.last || !r_out_valid || o_result.ready;
    assign pop          = i_item_valid && o_item_ready;

    assign over      = r_pos[POS_BITS];
    assign v_acc     = r_acc | varint_part(i_item.low7, r_shift);
    assign v_done    = !i_item.cont;
    assign v_bad     = i_item.cont && (r_shift >= 3'(MAX_VARINT_BYTES - 1));
    assign match     = (r_field == r_target);
    assign tag_wire  = v_acc[2:0];
    assign pos_inc   = r_pos + 1'b1;
    assign skip_last = (r_skip == 32'd1);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 29'd1;
            r_mode   <= MODE_VARINT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_FIELD: r_target <= i_cfg_data[FIELD_W-1:0];
                CFG_SEARCH_MODE:  r_mode   <= i_cfg_data[0];
                default:          r_target <= r_target;
            endcase
        end
    end

    // Next phase for one message byte.
    always_comb begin
        n_phase = r_phase;
        if (r_phase != PH_DONE && over) begin
            n_phase = PH_DONE;
        end else begin
            case (r_phase)
                PH_TAG: begin
                    if (v_bad) begin
                        n_phase = PH_DONE;
                    end else if (v_done) begin
                        case (tag_wire)
                            WIRE_VARINT:  n_phase = PH_VAL;
                            WIRE_LENGTH:  n_phase = PH_LEN;
                            WIRE_FIXED32: n_phase = PH_SKIP;
                            WIRE_FIXED64: n_phase = PH_SKIP;
                            default:      n_phase = PH_DONE;
                        endcase
                    end
                end
                PH_VAL: begin
                    if (v_bad || (v_done && r_mode == MODE_VARINT && match)) begin
                        n_phase = PH_DONE;
                    end else if (v_done) begin
                        n_phase = PH_TAG;
                    end
                end
                PH_LEN: begin
                    if (v_bad) begin
                        n_phase = PH_DONE;
                    end else if (v_done) begin
                        if (r_mode == MODE_BYTES && match) begin
                            n_phase = (v_acc == '0) ? PH_DONE : PH_MSKIP;
                        end else begin
                            n_phase = (v_acc == '0) ? PH_TAG : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (skip_last) begin
                        n_phase = PH_TAG;
                    end
                end
                PH_MSKIP: begin
                    if (skip_last) begin
                        n_phase = PH_DONE;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Datapath updates for one message byte.
    always_comb begin
        n_acc    = r_acc;
        n_shift  = r_shift;
        n_field  = r_field;
        n_skip   = r_skip;
        n_pos    = r_pos;
        n_status = r_status;
        n_value  = r_value;
        n_offset = r_offset;
        n_length = r_length;
        if (r_phase != PH_DONE && over) begin
            n_status = ST_TOO_LONG;
            n_value  = '0;
            n_offset = '0;
            n_length = '0;
        end else if (r_phase != PH_DONE) begin
            n_pos = pos_inc;
            case (r_phase)
                PH_TAG, PH_VAL, PH_LEN: begin
                    if (v_bad) begin
                        n_status = ST_MALFORMED;
                        n_value  = '0;
                        n_offset = '0;
                        n_length = '0;
                    end else if (!v_done) begin
                        n_acc   = v_acc;
                        n_shift = r_shift + 3'd1;
                    end else begin
                        n_acc   = '0;
                        n_shift = '0;
                        if (r_phase == PH_TAG) begin
                            n_field = v_acc[VALUE_W-1:3];
                            if (tag_wire == WIRE_FIXED32) begin
                                n_skip = FIXED32_BYTES;
                            end else if (tag_wire == WIRE_FIXED64) begin
                                n_skip = FIXED64_BYTES;
                            end else if (tag_wire != WIRE_VARINT &&
                                         tag_wire != WIRE_LENGTH) begin
                                n_status = ST_MALFORMED;
                                n_value  = '0;
                                n_offset = '0;
                                n_length = '0;
                            end
                        end else if (r_phase == PH_VAL) begin
                            if (r_mode == MODE_VARINT && match) begin
                                n_status = ST_FOUND;
                                n_value  = v_acc;
                                n_offset = '0;
                                n_length = '0;
                            end
                        end else begin
                            n_skip = v_acc;
                            if (r_mode == MODE_BYTES && match) begin
                                n_offset = OFFSET_W'(pos_inc);
                                n_length = v_acc[LENGTH_W-1:0];
                                if (v_acc == '0) begin
                                    n_status = ST_FOUND;
                                    n_value  = '0;
                                end
                            end
                        end
                    end
                end
                PH_SKIP, PH_MSKIP: begin
                    n_skip = r_skip - 32'd1;
                    if (r_phase == PH_MSKIP && skip_last) begin
                        n_status = ST_FOUND;
                        n_value  = '0;
                    end
                end
                default: n_skip = r_skip;
            endcase
        end
    end

    // Message result as seen after the closing byte.
    always_comb begin
        if (n_phase == PH_DONE) begin
            res_status = n_status;
            res_value  = n_value;
            res_offset = n_offset;
            res_length = n_length;
        end else begin
            res_status = (n_phase == PH_TAG && n_shift == 3'd0) ? ST_ABSENT : ST_PAST_END;
            res_value  = '0;
            res_offset = '0;
            res_length = '0;
        end
    end

    // Scan state; a closing byte returns everything to the start of a message.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TAG;
            r_acc    <= '0;
            r_shift  <= '0;
            r_field  <= '0;
            r_skip   <= '0;
            r_pos    <= '0;
            r_status <= ST_ABSENT;
            r_value  <= '0;
            r_offset <= '0;
            r_length <= '0;
        end else if (pop) begin
            if (i_item.last) begin
                r_phase  <= PH_TAG;
                r_acc    <= '0;
                r_shift  <= '0;
                r_field  <= '0;
                r_skip   <= '0;
                r_pos    <= '0;
                r_status <= ST_ABSENT;
                r_value  <= '0;
                r_offset <= '0;
                r_length <= '0;
            end else begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_shift  <= n_shift;
                r_field  <= n_field;
                r_skip   <= n_skip;
                r_pos    <= n_pos;
                r_status <= n_status;
                r_value  <= n_value;
                r_offset <= n_offset;
                r_length <= n_length;
            end
        end
    end

    // Result register handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_item.last) begin
            r_res_status <= res_status;
            r_res_value  <= res_value;
            r_res_offset <= res_offset;
            r_res_length <= res_length;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.scan_status  = r_res_status;
    assign o_result.field_value  = r_res_value;
    assign o_result.field_offset = r_res_offset;
    assign o_result.field_length = r_res_length;

endmodule

// ----- rtl/protobuf_field_scanner.sv -----
// Streaming protobuf field scanner.
// Message bytes enter on i_byte (valid/ready), one byte per transaction, with
// last_byte set on the final byte of each message. Exactly one result
// transaction leaves on o_result per message: a status, and the varint value
// or the offset and length of the contents of the first matching field.
// The search target and mode are set through the write port (index 0 is the
// field number, index 1 the mode) while no message is in flight.
// The block takes one byte per cycle while i_byte.ready is high. A byte
// passes an input register, a two-entry queue and the scan state machine.
// The scanner handles one byte per cycle, unless a closing byte waits for the
// result register, as a byte only updates varint, skip and position state.
// When the receiver stalls, the result waits in the output register; bytes
// keep flowing until a second closing byte reaches the scanner, and then the
// queue and input register fill and i_byte.ready drops.
// Reset clears all in-flight bytes and any pending result, sets the target
// field to 1 and selects varint mode.
module protobuf_field_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pfs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    pfs_in_if.sink                              i_byte,
    pfs_out_if.source                           o_result
);
    import pfs_pkg::*;

    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  pop_valid;
    logic  pop_ready;
    t_item pop_item;

    // Front: input register and byte classification.
    pfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    // Decoupling queue between front and scanner.
    pfs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    // Back: wire-format scan and result register.
    pfs_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (pop_valid),
        .o_item_ready (pop_ready),
        .i_item       (pop_item),
        .o_result     (o_result)
    );

endmodule
